@@ rtl/core/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometer pressure and temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned RawW   = 24;
  localparam int unsigned CalW   = 16;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PressW = 24;
  localparam int unsigned DtW    = 25;  // D2 - C5*2^8
  localparam int unsigned ProdW  = 41;  // dT * 16-bit coefficient
  localparam int unsigned OffW   = 36;
  localparam int unsigned SensW  = 35;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned TempBase  = 2000;
  localparam int unsigned TempShift = 23;
  localparam int unsigned OffShift  = 6;
  localparam int unsigned SensShift = 7;
  localparam int unsigned PrdShift  = 21;
  localparam int unsigned PShift    = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESS_SENS = 3'd0,
    REG_PRESS_OFF  = 3'd1,
    REG_SENS_TCO   = 3'd2,
    REG_OFF_TCO    = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_COEF  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_beat_t;

  typedef struct packed {
    logic signed [TempW-1:0]  temperature_centi;
    logic signed [PressW-1:0] pressure_pa;
  } out_beat_t;

  // Handed from the temperature front end to the pressure back end.
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic [RawW-1:0]         raw_pressure;
  } mid_t;

endpackage

@@ rtl/core/baro_pressure_temp_compensation.sv @@
// Throughput: one beat per cycle while the output accepts; six register stages, the
// 24x35 pressure product split into two partial products so no stage holds more than
// one multiplier level.
// Ready runs combinationally back through all six stages; an empty stage still takes
// a beat while the output waits, so bubbles are squeezed out.
// Reset (rst_ni, asynchronous, active low): pipeline empty, calibration words zero.
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// First-order barometer compensation: raw D1/D2 conversions in,
// temperature in centidegrees and pressure in pascals out.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // calibration write port
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CalW-1:0]      cfg_data_i,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bpc_pkg::in_beat_t             in_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bpc_pkg::out_beat_t            out_data_o
);
  import bpc_pkg::*;

  cal_t cal_d, cal_q;
  logic mid_valid, mid_ready;
  mid_t mid_data;

  // Calibration words C1..C6; unknown indexes are dropped.
  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PRESS_SENS: cal_d.c1 = cfg_data_i;
        REG_PRESS_OFF:  cal_d.c2 = cfg_data_i;
        REG_SENS_TCO:   cal_d.c3 = cfg_data_i;
        REG_OFF_TCO:    cal_d.c4 = cfg_data_i;
        REG_REF_TEMP:   cal_d.c5 = cfg_data_i;
        REG_TEMP_COEF:  cal_d.c6 = cfg_data_i;
        default:        cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  // Stages 1-3: dT, the three dT products, TEMP / OFF / SENS.
  bpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  // Stages 4-6: D1*SENS, shift, offset subtract, final shift.
  bpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // An empty output stage means nothing can block the input.
  a_ready_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with output stage empty");

  // A calibration write lands in the addressed word.
  a_cfg_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_TEMP_COEF) |=> cal_q.c6 == $past(cfg_data_i)
  ) else $error("temperature coefficient write lost");

  // A stalled mid-pipeline beat holds until the back end takes it.
  a_mid_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid_data)
  ) else $error("mid-pipeline beat dropped while stalled");

endmodule

@@ rtl/core/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// Stages 1-3: temperature difference, coefficient products, then TEMP,
// OFF and SENS.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpc_pkg::cal_t     cal_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpc_pkg::in_beat_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpc_pkg::mid_t     out_data_o
);
  import bpc_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [DtW-1:0]   dt_d, dt_q;
  logic [RawW-1:0]         d1a_q, d1b_q;
  logic signed [ProdW-1:0] tprod_d, tprod_q, oprod_d, oprod_q, sprod_d, sprod_q;
  logic signed [ProdW-1:0] tbias, tsh, osh, ssh;
  mid_t                    mid_d, mid_q;

  // stage ready: a stage takes a beat when empty or when it drains
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: dT
  assign dt_d = $signed({1'b0, in_data_i.raw_temperature})
              - $signed({1'b0, cal_i.c5, 8'b0});

  // stage 2: products of dT with C6, C4, C3
  assign tprod_d = dt_q * $signed({1'b0, cal_i.c6});
  assign oprod_d = dt_q * $signed({1'b0, cal_i.c4});
  assign sprod_d = dt_q * $signed({1'b0, cal_i.c3});

  // stage 3: truncating divide for TEMP, floor shifts for OFF and SENS
  assign tbias = tprod_q + (tprod_q[ProdW-1] ? ProdW'((1 << TempShift) - 1) : '0);
  assign tsh   = tbias >>> TempShift;
  assign osh   = oprod_q >>> OffShift;
  assign ssh   = sprod_q >>> SensShift;

  always_comb begin
    mid_d.temp         = TempW'(tsh) + TempW'(TempBase);
    mid_d.off          = OffW'(osh) + {3'b0, cal_i.c2, 17'b0};
    mid_d.sens         = SensW'(ssh) + {3'b0, cal_i.c1, 16'b0};
    mid_d.raw_pressure = d1b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      dt_q  <= dt_d;
      d1a_q <= in_data_i.raw_pressure;
    end
    if (rdy2 && v1_q) begin
      tprod_q <= tprod_d;
      oprod_q <= oprod_d;
      sprod_q <= sprod_d;
      d1b_q   <= d1a_q;
    end
    if (rdy3 && v2_q) begin
      mid_q <= mid_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = mid_q;

endmodule

@@ rtl/core/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back
// Stages 4-6: D1*SENS as two partial products, sum and shift, then
// subtract OFF and scale to pascals.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpc_pkg::mid_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bpc_pkg::out_beat_t out_data_o
);
  import bpc_pkg::*;

  localparam int unsigned LoW   = 18;                 // SENS low slice, unsigned
  localparam int unsigned HiW   = SensW - LoW;        // SENS high slice, signed
  localparam int unsigned PpW   = RawW + LoW;         // partial product width
  localparam int unsigned FullW = PpW + LoW;          // full product width
  localparam int unsigned ShW   = FullW - PrdShift;   // after >> 21
  localparam int unsigned DifW  = ShW + 1;

  logic v4_q, v5_q, v6_q;
  logic rdy4, rdy5, rdy6;

  logic [PpW-1:0]          plo_d, plo_q;
  logic signed [PpW-1:0]   phi_d, phi_q;
  logic signed [FullW-1:0] prod;
  logic signed [ShW-1:0]   psh_d, psh_q;
  logic signed [OffW-1:0]  off4_q, off5_q;
  logic signed [TempW-1:0] temp4_q, temp5_q;
  logic signed [DifW-1:0]  diff, dsh;
  out_beat_t               res_d, res_q;

  assign rdy6 = !v6_q || out_ready_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign in_ready_o = rdy4;

  // stage 4: partial products
  assign plo_d = PpW'(in_data_i.raw_pressure) * PpW'(in_data_i.sens[LoW-1:0]);
  assign phi_d = $signed({1'b0, in_data_i.raw_pressure})
               * $signed(in_data_i.sens[LoW +: HiW]);

  // stage 5: recombine and floor-shift
  assign prod  = $signed({phi_q, {LoW{1'b0}}}) + $signed({{LoW{1'b0}}, plo_q});
  assign psh_d = ShW'(prod >>> PrdShift);

  // stage 6: subtract offset, floor-shift to pascals
  assign diff = DifW'(psh_q) - DifW'(off5_q);
  assign dsh  = diff >>> PShift;

  always_comb begin
    res_d.temperature_centi = temp5_q;
    res_d.pressure_pa       = PressW'(dsh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      off4_q  <= in_data_i.off;
      temp4_q <= in_data_i.temp;
    end
    if (rdy5 && v4_q) begin
      psh_q   <= psh_d;
      off5_q  <= off4_q;
      temp5_q <= temp4_q;
    end
    if (rdy6 && v5_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = res_q;

endmodule
